@@ rtl/core/nat_pkg.sv @@
package nat_pkg;

    // sizing of the tracker
    localparam int CHANNELS          = 8;
    localparam int SLOTS_PER_CHANNEL = 16;
    localparam int TOTAL_SLOTS       = CHANNELS * SLOTS_PER_CHANNEL;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = (SLOTS_PER_CHANNEL > 1) ? $clog2(SLOTS_PER_CHANNEL) : 1;
    localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

    // field widths
    localparam int CHAN_W   = 3;
    localparam int PITCH_W  = 7;
    localparam int MODE_W   = 3;
    localparam int TARGET_W = 4;

    typedef logic [SLOTS_PER_CHANNEL-1:0] t_slot_mask;
    typedef logic [SLOT_W-1:0]            t_slot_idx;

    // articulation modes
    localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STACCATO = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LEGATO   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SUSTAIN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INFINITE = 3'd4;

    // event kinds
    localparam logic KIND_OFF = 1'b0;
    localparam logic KIND_ON  = 1'b1;

    // priority encoder: index of the lowest set bit, zero when none
    function automatic t_slot_idx lowest_one(input t_slot_mask v);
        t_slot_idx idx;
        idx = '0;
        for (int i = SLOTS_PER_CHANNEL - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/nat_ram.sv @@
module nat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/note_articulation_tracker_core.sv @@
// flow: a release reads the pitch of each held slot from the pitch store and sends its note-off,
//   then the note-on if the request holds one; an infinite, legato or sustain note first searches
//   the held slots for its pitch, and a legato or sustain miss then releases the whole set;
//   events leave one per cycle while the receiver is ready
// requests: taken only while idle, so a new request waits until the current one is finished
// reset: synchronous active low; clears all held-note flags and the control state, not the pitch memory
module note_articulation_tracker_core
    import nat_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CHAN_W-1:0]   i_chan,
    input  logic                i_has_note,
    input  logic [PITCH_W-1:0]  i_pitch,
    input  logic [MODE_W-1:0]   i_mode,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_event_kind,
    output logic [TARGET_W-1:0] o_target,
    output logic [PITCH_W-1:0]  o_event_pitch,
    output logic                o_last
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_FIND    = 2'd1;
    localparam logic [1:0] ST_RELEASE = 2'd2;
    localparam logic [1:0] ST_EMIT    = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CH_W-1:0]     r_ch;
    logic                r_has_note;
    logic [PITCH_W-1:0]  r_pitch;
    logic [MODE_W-1:0]   r_mode;
    logic [TARGET_W-1:0] r_target;
    logic [ADDR_W-1:0]   r_base;
    t_slot_mask          r_mask, n_mask;
    logic                r_rd_vld, n_rd_vld;
    logic                r_rd_last, n_rd_last;
    logic                r_emit_kind, n_emit_kind;
    logic                r_add, n_add;
    t_slot_mask          r_valid [CHANNELS];

    logic                r_out_vld;
    logic                r_out_kind;
    logic [TARGET_W-1:0] r_out_target;
    logic [PITCH_W-1:0]  r_out_pitch;
    logic                r_out_last;

    logic                in_accept;
    logic                in_ok;
    logic [CH_W-1:0]     in_ch;
    t_slot_idx           pick;
    t_slot_mask          mask_left;
    t_slot_mask          cur_valid;
    t_slot_idx           free_slot;
    logic                set_full;
    logic                out_free;
    logic                hit;
    logic                ram_re;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [PITCH_W-1:0]  ram_rdata;
    logic                out_load;
    logic                ld_kind;
    logic [PITCH_W-1:0]  ld_pitch;
    logic                ld_last;
    logic                valid_clr;
    logic                valid_set;

    // pitch store, one entry per slot
    nat_ram #(
        .WIDTH (PITCH_W),
        .DEPTH (TOTAL_SLOTS)
    ) u_pitch_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_pitch),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // request handshake and channel decode
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_ok      = (32'(i_chan) < CHANNELS);
    assign in_ch      = CH_W'(i_chan);

    // slot walk and free-slot search
    assign pick      = lowest_one(r_mask);
    assign mask_left = r_mask & ~(SLOTS_PER_CHANNEL'(1) << pick);
    assign cur_valid = r_valid[r_ch];
    assign free_slot = lowest_one(~cur_valid);
    assign set_full  = &cur_valid;
    assign out_free  = !r_out_vld || i_out_ready;
    assign hit       = r_rd_vld && (ram_rdata == r_pitch);
    assign ram_raddr = r_base + ADDR_W'(pick);
    assign ram_waddr = r_base + ADDR_W'(free_slot);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mask      = r_mask;
        n_rd_vld    = r_rd_vld;
        n_rd_last   = r_rd_last;
        n_emit_kind = r_emit_kind;
        n_add       = r_add;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        out_load    = 1'b0;
        ld_kind     = KIND_OFF;
        ld_pitch    = ram_rdata;
        ld_last     = 1'b0;
        valid_clr   = 1'b0;
        valid_set   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_rd_vld = 1'b0;
                if (in_accept && in_ok) begin
                    n_mask      = r_valid[in_ch];
                    n_emit_kind = KIND_ON;
                    n_add       = 1'b1;
                    if (i_has_note) begin
                        if (i_mode == MODE_INFINITE || i_mode == MODE_LEGATO ||
                            i_mode == MODE_SUSTAIN) begin
                            n_state = ST_FIND;
                        end else begin
                            n_state = ST_RELEASE;
                        end
                    end else if (i_mode <= MODE_LEGATO) begin
                        n_state = ST_RELEASE;
                    end
                end
            end
            ST_FIND: begin
                if (hit || r_mask == '0) begin
                    n_rd_vld = 1'b0;
                    if (r_mode == MODE_INFINITE) begin
                        n_emit_kind = hit ? KIND_OFF : KIND_ON;
                        n_add       = !hit;
                        n_state     = ST_EMIT;
                    end else if (hit) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_mask  = cur_valid;
                        n_state = ST_RELEASE;
                    end
                end else begin
                    ram_re   = 1'b1;
                    n_mask   = mask_left;
                    n_rd_vld = 1'b1;
                end
            end
            ST_RELEASE: begin
                if (r_rd_vld && out_free) begin
                    out_load = 1'b1;
                    ld_kind  = KIND_OFF;
                    ld_pitch = ram_rdata;
                    ld_last  = r_rd_last && !r_has_note;
                end
                if (!r_rd_vld || out_free) begin
                    if (r_mask != '0) begin
                        ram_re    = 1'b1;
                        n_mask    = mask_left;
                        n_rd_vld  = 1'b1;
                        n_rd_last = (mask_left == '0);
                    end else begin
                        n_rd_vld  = 1'b0;
                        valid_clr = 1'b1;
                        n_state   = r_has_note ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ld_kind  = r_emit_kind;
                    ld_pitch = r_pitch;
                    ld_last  = 1'b1;
                    if (r_add && !set_full) begin
                        ram_we    = 1'b1;
                        valid_set = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    // request fields and walk state
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch       <= in_ch;
            r_has_note <= i_has_note;
            r_pitch    <= i_pitch;
            r_mode     <= i_mode;
            r_target   <= TARGET_W'(i_chan) + TARGET_W'(1);
            r_base     <= ADDR_W'(32'(i_chan) * SLOTS_PER_CHANNEL);
        end
        r_mask      <= n_mask;
        r_rd_last   <= n_rd_last;
        r_emit_kind <= n_emit_kind;
        r_add       <= n_add;
    end

    // held-note flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_valid[c] <= '0;
            end
        end else if (valid_clr) begin
            r_valid[r_ch] <= '0;
        end else if (valid_set) begin
            r_valid[r_ch][free_slot] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind   <= ld_kind;
            r_out_target <= r_target;
            r_out_pitch  <= ld_pitch;
            r_out_last   <= ld_last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_event_kind  = r_out_kind;
    assign o_target      = r_out_target;
    assign o_event_pitch = r_out_pitch;
    assign o_last        = r_out_last;

    // the pitch store never sees a read and a write together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_re && ram_we))
        else $error("pitch store read and write in the same cycle");

    // a finished release leaves the channel with no held notes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RELEASE && n_state != ST_RELEASE) |=> (r_valid[r_ch] == '0))
        else $error("held notes remain after release");

    // the closing event of a request is flagged last
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_load) |=> (r_out_vld && r_out_last))
        else $error("closing event not flagged last");

    // outstanding reads only while walking slots
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_FIND || r_state == ST_RELEASE))
        else $error("slot read outstanding outside a walk");

endmodule

@@ tb/sv/tb.sv @@
// one note event as seen on the output channel
typedef struct packed {
    logic                             kind;
    logic [nat_pkg::TARGET_W-1:0]     target;
    logic [nat_pkg::PITCH_W-1:0]      pitch;
    logic                             last;
} note_event_t;

// tracks the sounding notes per channel and checks the event stream
class articulation_check;
    bit                          sounding[nat_pkg::CHANNELS][nat_pkg::SLOTS_PER_CHANNEL];
    logic [nat_pkg::PITCH_W-1:0] sounding_pitch[nat_pkg::CHANNELS][nat_pkg::SLOTS_PER_CHANNEL];
    note_event_t                 due_events[$];
    note_event_t                 step_events[$];
    int                          bad_count;
    int                          event_count;
    int                          dropped_adds;

    function int pending();
        return due_events.size();
    endfunction

    // note-offs for every held note of a channel, lowest slot first
    function void release_set(int ch, logic [nat_pkg::TARGET_W-1:0] tgt);
        note_event_t e;
        for (int s = 0; s < nat_pkg::SLOTS_PER_CHANNEL; s++) begin
            if (sounding[ch][s]) begin
                e.kind   = nat_pkg::KIND_OFF;
                e.target = tgt;
                e.pitch  = sounding_pitch[ch][s];
                e.last   = 1'b0;
                step_events.push_back(e);
                sounding[ch][s] = 1'b0;
            end
        end
    endfunction

    // lowest free slot takes the note, a full set drops it
    function void add_note(int ch, logic [nat_pkg::PITCH_W-1:0] p);
        for (int s = 0; s < nat_pkg::SLOTS_PER_CHANNEL; s++) begin
            if (!sounding[ch][s]) begin
                sounding[ch][s]       = 1'b1;
                sounding_pitch[ch][s] = p;
                return;
            end
        end
        dropped_adds++;
    endfunction

    // an accepted request: work out the events it causes
    function void take_step(logic [nat_pkg::CHAN_W-1:0] chan, logic has_note,
                            logic [nat_pkg::PITCH_W-1:0] pitch,
                            logic [nat_pkg::MODE_W-1:0] mode);
        int                           ch;
        int                           hit;
        logic [nat_pkg::TARGET_W-1:0] tgt;
        note_event_t                  e;
        ch = int'(chan);
        step_events.delete();
        if (ch >= nat_pkg::CHANNELS) begin
            return;
        end
        tgt = nat_pkg::TARGET_W'(ch + 1);
        e.target = tgt;
        e.pitch  = pitch;
        e.last   = 1'b0;
        if (has_note) begin
            hit = -1;
            for (int s = nat_pkg::SLOTS_PER_CHANNEL - 1; s >= 0; s--) begin
                if (sounding[ch][s] && sounding_pitch[ch][s] == pitch) begin
                    hit = s;
                end
            end
            if (mode == nat_pkg::MODE_INFINITE) begin
                // toggle: a held note is switched off but stays recorded
                if (hit >= 0) begin
                    e.kind = nat_pkg::KIND_OFF;
                    step_events.push_back(e);
                end else begin
                    e.kind = nat_pkg::KIND_ON;
                    step_events.push_back(e);
                    add_note(ch, pitch);
                end
            end else if ((mode == nat_pkg::MODE_LEGATO || mode == nat_pkg::MODE_SUSTAIN)
                         && hit >= 0) begin
                // already sounding, nothing happens
            end else begin
                release_set(ch, tgt);
                e.kind = nat_pkg::KIND_ON;
                step_events.push_back(e);
                add_note(ch, pitch);
            end
        end else if (mode == nat_pkg::MODE_NORMAL || mode == nat_pkg::MODE_STACCATO ||
                     mode == nat_pkg::MODE_LEGATO) begin
            release_set(ch, tgt);
        end
        // mark the final event of this request
        foreach (step_events[i]) begin
            e      = step_events[i];
            e.last = (i == step_events.size() - 1);
            due_events.push_back(e);
        end
    endfunction

    function void note_mismatch(string msg);
        bad_count++;
        if (bad_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    // compare one output event with the oldest one due
    function void check_event(note_event_t got);
        note_event_t want;
        event_count++;
        if (due_events.size() == 0) begin
            note_mismatch($sformatf("unexpected event kind %0d target %0d pitch %0d last %0d",
                                    got.kind, got.target, got.pitch, got.last));
            return;
        end
        want = due_events.pop_front();
        if (got.kind !== want.kind || got.target !== want.target ||
            got.pitch !== want.pitch || got.last !== want.last) begin
            note_mismatch($sformatf(
                "event %0d: expected kind %0d target %0d pitch %0d last %0d, got %0d %0d %0d %0d",
                event_count, want.kind, want.target, want.pitch, want.last,
                got.kind, got.target, got.pitch, got.last));
        end
    endfunction
endclass

module tb;
    import nat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [CHAN_W-1:0]   i_chan        = '0;
    logic                i_has_note    = 1'b0;
    logic [PITCH_W-1:0]  i_pitch       = '0;
    logic [MODE_W-1:0]   i_mode        = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic                o_event_kind;
    logic [TARGET_W-1:0] o_target;
    logic [PITCH_W-1:0]  o_event_pitch;
    logic                o_last;

    articulation_check sb = new();
    int                burst_left = 0;
    int                step_count = 0;
    int                directed_count;
    logic [7:0]        ready_pat  = 8'hff;
    int                pat_left   = 0;

    note_articulation_tracker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_chan        (i_chan),
        .i_has_note    (i_has_note),
        .i_pitch       (i_pitch),
        .i_mode        (i_mode),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_target      (o_target),
        .o_event_pitch (o_event_pitch),
        .o_last        (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls on a rotating pattern, swapped for a randomly chosen one when its run ends
    always @(posedge i_clk) begin
        if (pat_left == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pat <= 8'hff;
                1: ready_pat <= 8'($urandom) | 8'h10;
                2: ready_pat <= 8'h01;
                default: ready_pat <= 8'hf0;
            endcase
            pat_left <= $urandom_range(20, 80);
        end else begin
            ready_pat <= {ready_pat[6:0], ready_pat[7]};
            pat_left  <= pat_left - 1;
        end
        i_out_ready <= ready_pat[0];
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_event('{o_event_kind, o_target, o_event_pitch, o_last});
        end
    end

    // one request, sent in bursts with idle gaps between them
    task automatic send_step(input logic [CHAN_W-1:0] c, input logic n,
                             input logic [PITCH_W-1:0] p, input logic [MODE_W-1:0] m);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        i_in_valid <= 1'b1;
        i_chan     <= c;
        i_has_note <= n;
        i_pitch    <= p;
        i_mode     <= m;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.take_step(c, n, p, m);
        step_count++;
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
        end
    endtask

    // fill one channel in infinite mode, often past capacity, then let it go
    task automatic fill_channel();
        logic [CHAN_W-1:0]  c;
        logic [PITCH_W-1:0] p0;
        int                 cnt;
        c   = CHAN_W'($urandom_range(0, CHANNELS - 1));
        p0  = PITCH_W'($urandom);
        cnt = $urandom_range(16, 19);
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_step(c, 1'b1, p0, MODE_INFINITE);
            end else begin
                send_step(c, 1'b1, PITCH_W'(p0 + i), MODE_INFINITE);
            end
        end
        case ($urandom_range(0, 3))
            0: send_step(c, 1'b1, PITCH_W'($urandom), MODE_NORMAL);
            1: send_step(c, 1'b0, PITCH_W'($urandom), MODE_STACCATO);
            2: send_step(c, 1'b1, PITCH_W'(p0 - 1), MODE_LEGATO);
            default: send_step(c, 1'b0, PITCH_W'($urandom), MODE_NORMAL);
        endcase
    endtask

    // short phrase on one channel from a small pitch pool, so notes repeat
    task automatic play_phrase();
        logic [CHAN_W-1:0]  c;
        logic [PITCH_W-1:0] base;
        int                 len;
        c    = CHAN_W'($urandom_range(0, CHANNELS - 1));
        base = PITCH_W'($urandom);
        len  = $urandom_range(3, 8);
        repeat (len) begin
            send_step(c, ($urandom_range(0, 4) != 0), PITCH_W'(base + $urandom_range(0, 3)),
                      MODE_W'($urandom_range(0, 4)));
        end
    endtask

    // stimulus
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pitch extremes, every mode, toggles, held notes, undefined modes
        send_step(3'd0, 1'b1, 7'd0,   MODE_NORMAL);
        send_step(3'd0, 1'b1, 7'd127, MODE_NORMAL);
        send_step(3'd0, 1'b0, 7'd0,   MODE_STACCATO);
        send_step(3'd1, 1'b1, 7'd10,  MODE_INFINITE);
        send_step(3'd1, 1'b1, 7'd20,  MODE_INFINITE);
        send_step(3'd1, 1'b1, 7'd10,  MODE_INFINITE);
        send_step(3'd1, 1'b1, 7'd20,  MODE_LEGATO);
        send_step(3'd1, 1'b1, 7'd10,  MODE_SUSTAIN);
        send_step(3'd1, 1'b0, 7'd127, MODE_SUSTAIN);
        send_step(3'd1, 1'b0, 7'd127, MODE_INFINITE);
        send_step(3'd1, 1'b1, 7'd30,  MODE_SUSTAIN);
        send_step(3'd1, 1'b1, 7'd40,  MODE_LEGATO);
        send_step(3'd1, 1'b0, 7'd0,   MODE_LEGATO);
        send_step(3'd7, 1'b1, 7'd127, MODE_INFINITE);
        send_step(3'd7, 1'b1, 7'd0,   MODE_INFINITE);
        send_step(3'd7, 1'b1, 7'd64,  MODE_W'(5));
        send_step(3'd7, 1'b0, 7'd64,  MODE_W'(6));
        send_step(3'd7, 1'b1, 7'd1,   MODE_W'(7));
        send_step(3'd7, 1'b0, 7'd1,   MODE_W'(7));
        send_step(3'd2, 1'b0, 7'd85,  MODE_NORMAL);
        send_step(3'd2, 1'b1, 7'd85,  MODE_STACCATO);
        send_step(3'd2, 1'b1, 7'd42,  MODE_STACCATO);
        send_step(3'd2, 1'b0, 7'd42,  MODE_NORMAL);
        directed_count = step_count;

        // random: full sets, phrases with repeats, and raw noise
        fill_channel();
        while (step_count < directed_count + 200) begin
            case ($urandom_range(0, 9))
                0, 1: fill_channel();
                2, 3, 4, 5, 6: play_phrase();
                default: send_step(CHAN_W'($urandom), 1'($urandom), PITCH_W'($urandom),
                                   MODE_W'($urandom));
            endcase
        end
        if (burst_left != 0) begin
            i_in_valid <= 1'b0;
        end

        // drain, then allow stray events to show up
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);

        $display("requests sent: %0d (%0d directed), events checked: %0d",
                 step_count, directed_count, sb.event_count);
        $display("adds dropped on full sets: %0d, mismatches: %0d",
                 sb.dropped_adds, sb.bad_count);
        if (sb.bad_count == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hang guard
    initial begin
        #5ms;
        $display("timeout after %0d requests", step_count);
        $display("status: fail");
        $finish;
    end

endmodule
